[rtl/core/msidir_pkg.sv]
package msidir_pkg;

	// fixed field widths of the request and response beats
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 10;
	localparam int REQ_W   = 3;
	localparam int MASK_W  = 8;
	localparam int STATE_W = 2;

	localparam int NUM_PROCS_DEF   = 8;
	localparam int DIR_ENTRIES_DEF = 1024;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INVAL  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [STATE_W-1:0] {
		ST_INVALID  = 2'd0,
		ST_SHARED   = 2'd1,
		ST_MODIFIED = 2'd2,
		ST_RSVD     = 2'd3
	} blk_state_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_LOOK,
		S_SCAN,
		S_DONE
	} fsm_t;

endpackage

[rtl/core/msidir_req_if.sv]
interface msidir_req_if;
	logic                         valid;
	logic                         ready;
	logic [msidir_pkg::OP_W-1:0]   op;
	logic [msidir_pkg::ADDR_W-1:0] block_address;
	logic [msidir_pkg::REQ_W-1:0]  requester;

	modport source (output valid, output op, output block_address, output requester,
		input ready);
	modport sink (input valid, input op, input block_address, input requester,
		output ready);
endinterface

[rtl/core/msidir_rsp_if.sv]
interface msidir_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          from_memory;
	logic [msidir_pkg::REQ_W-1:0]   supplier;
	logic [msidir_pkg::MASK_W-1:0]  downgrade_mask;
	logic [msidir_pkg::MASK_W-1:0]  invalidate_mask;
	logic [msidir_pkg::STATE_W-1:0] new_state;

	modport source (output valid, output from_memory, output supplier,
		output downgrade_mask, output invalidate_mask, output new_state, input ready);
	modport sink (input valid, input from_memory, input supplier,
		input downgrade_mask, input invalidate_mask, input new_state, output ready);
endinterface

[rtl/core/msidir_ram.sv]
module msidir_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/msi_directory_controller.sv]
// channel  dir  payload                                              beat taken when
// req      in   op, block_address, requester                         req.valid && req.ready
// rsp      out  from_memory, supplier, downgrade_mask,               rsp.valid && rsp.ready
//               invalidate_mask, new_state
//
// One request at a time: accept, wrap address (one subtract of DIR_ENTRIES per cycle,
// none when DIR_ENTRIES >= 1024), directory read, supplier scan (one sharer bit per
// cycle from the top, stopping at the first set bit or at bit 0), write-back.
// After reset the directory RAM is swept to zero, with req.ready low.
// The response sits in an output register; a stalled rsp holds only the write-back step.
module msi_directory_controller #(
	parameter int NUM_PROCS   = msidir_pkg::NUM_PROCS_DEF,
	parameter int DIR_ENTRIES = msidir_pkg::DIR_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	msidir_req_if.sink    req,
	msidir_rsp_if.source  rsp
);

	localparam int AW       = $clog2(DIR_ENTRIES);
	localparam int IW       = (AW > msidir_pkg::ADDR_W) ? AW : msidir_pkg::ADDR_W;
	localparam int EW       = msidir_pkg::STATE_W + NUM_PROCS;
	localparam int CW       = $clog2(NUM_PROCS);
	localparam int SW       = (CW > msidir_pkg::REQ_W) ? CW : msidir_pkg::REQ_W;
	localparam int MW       = (NUM_PROCS > msidir_pkg::MASK_W) ? NUM_PROCS : msidir_pkg::MASK_W;
	localparam int RED_STEP = (DIR_ENTRIES < 1024) ? DIR_ENTRIES : 0;

	msidir_pkg::fsm_t state_q, state_d;

	logic [AW-1:0]                     clr_q;
	logic [msidir_pkg::ADDR_W-1:0]     red_q;
	msidir_pkg::op_t                   op_q;
	logic [msidir_pkg::REQ_W-1:0]      req_id_q;
	logic [msidir_pkg::STATE_W-1:0]    st_q;
	logic [NUM_PROCS-1:0]              sh_q;
	logic [CW-1:0]                     cnt_q;

	logic                              ovalid_q;
	logic                              ofrom_q;
	logic [msidir_pkg::REQ_W-1:0]      osup_q;
	logic [msidir_pkg::MASK_W-1:0]     odown_q;
	logic [msidir_pkg::MASK_W-1:0]     oinval_q;
	logic [msidir_pkg::STATE_W-1:0]    onew_q;

	logic                              ram_we;
	logic [AW-1:0]                     ram_waddr;
	logic [EW-1:0]                     ram_wdata;
	logic [AW-1:0]                     ram_raddr;
	logic [EW-1:0]                     ram_rdata;

	logic                              red_big;
	logic [IW-1:0]                     idx_ext;
	logic [AW-1:0]                     idx;
	logic                              scan_stop;
	logic                              rsp_load;
	logic                              req_acc;

	logic [NUM_PROCS-1:0]              req_bit;
	logic                              hit;
	logic                              r_from;
	logic [NUM_PROCS-1:0]              r_down, r_inval, r_sh;
	logic [msidir_pkg::STATE_W-1:0]    r_st;
	logic [SW-1:0]                     sup_ext;
	logic [msidir_pkg::REQ_W-1:0]      r_sup;
	logic [MW-1:0]                     down_ext, inval_ext;

	msidir_ram #(
		.WIDTH (EW),
		.DEPTH (DIR_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// wrap unit: one compare and subtract of DIR_ENTRIES
	assign red_big   = 32'(red_q) >= 32'(DIR_ENTRIES);
	assign idx_ext   = IW'(red_q);
	assign idx       = idx_ext[AW-1:0];
	assign scan_stop = sh_q[cnt_q] || (cnt_q == '0);
	assign req_acc   = req.valid && req.ready;

	always_comb begin
		for (int i = 0; i < NUM_PROCS; i++) begin
			req_bit[i] = (32'(req_id_q) == i);
		end
	end

	// response and entry update
	always_comb begin
		hit     = (st_q != msidir_pkg::ST_INVALID);
		r_from  = 1'b0;
		r_down  = '0;
		r_inval = '0;
		r_sh    = sh_q;
		r_st    = st_q;
		sup_ext = SW'(cnt_q);
		r_sup   = '0;
		case (op_q)
			msidir_pkg::OP_UNUSED: begin
			end
			msidir_pkg::OP_INVAL: begin
				if (hit) begin
					r_inval = sh_q & ~req_bit;
					r_sh    = req_bit;
					r_st    = msidir_pkg::ST_MODIFIED;
				end
			end
			default: begin
				if (hit) begin
					// hit with no sharers falls back to memory
					if (sh_q == '0) begin
						r_from = 1'b1;
					end else begin
						r_sup = sup_ext[msidir_pkg::REQ_W-1:0];
					end
					if (op_q == msidir_pkg::OP_READ) begin
						r_down = sh_q & ~req_bit;
						r_sh   = sh_q | req_bit;
						r_st   = msidir_pkg::ST_SHARED;
					end else begin
						r_inval = sh_q & ~req_bit;
						r_sh    = req_bit;
						r_st    = msidir_pkg::ST_MODIFIED;
					end
				end else begin
					r_from = 1'b1;
					r_sh   = sh_q | req_bit;
					r_st   = (op_q == msidir_pkg::OP_READ) ? msidir_pkg::ST_SHARED
						: msidir_pkg::ST_MODIFIED;
				end
			end
		endcase
		down_ext  = MW'(r_down);
		inval_ext = MW'(r_inval);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msidir_pkg::S_CLEAR: begin
				if (clr_q == AW'(DIR_ENTRIES - 1)) begin
					state_d = msidir_pkg::S_IDLE;
				end
			end
			msidir_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = msidir_pkg::S_REDUCE;
				end
			end
			msidir_pkg::S_REDUCE: begin
				if (!red_big) begin
					state_d = msidir_pkg::S_LOOK;
				end
			end
			msidir_pkg::S_LOOK: state_d = msidir_pkg::S_SCAN;
			msidir_pkg::S_SCAN: begin
				if (scan_stop) begin
					state_d = msidir_pkg::S_DONE;
				end
			end
			msidir_pkg::S_DONE: begin
				if (!ovalid_q || rsp.ready) begin
					state_d = msidir_pkg::S_IDLE;
				end
			end
			default: state_d = msidir_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = {r_st, r_sh};
		ram_raddr = idx;
		rsp_load  = 1'b0;
		unique case (state_q)
			msidir_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			msidir_pkg::S_IDLE: req.ready = 1'b1;
			msidir_pkg::S_DONE: begin
				rsp_load = !ovalid_q || rsp.ready;
				ram_we   = rsp_load;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msidir_pkg::S_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == msidir_pkg::S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (rsp_load) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= msidir_pkg::op_t'(req.op);
			red_q    <= req.block_address;
			req_id_q <= req.requester;
		end
		if (state_q == msidir_pkg::S_REDUCE && red_big) begin
			red_q <= red_q - msidir_pkg::ADDR_W'(RED_STEP);
		end
		if (state_q == msidir_pkg::S_LOOK) begin
			st_q  <= ram_rdata[EW-1 -: msidir_pkg::STATE_W];
			sh_q  <= ram_rdata[NUM_PROCS-1:0];
			cnt_q <= CW'(NUM_PROCS - 1);
		end
		if (state_q == msidir_pkg::S_SCAN && !scan_stop) begin
			cnt_q <= cnt_q - CW'(1);
		end
		if (rsp_load) begin
			ofrom_q  <= r_from;
			osup_q   <= r_sup;
			odown_q  <= down_ext[msidir_pkg::MASK_W-1:0];
			oinval_q <= inval_ext[msidir_pkg::MASK_W-1:0];
			onew_q   <= r_st;
		end
	end

	assign rsp.valid           = ovalid_q;
	assign rsp.from_memory     = ofrom_q;
	assign rsp.supplier        = osup_q;
	assign rsp.downgrade_mask  = odown_q;
	assign rsp.invalidate_mask = oinval_q;
	assign rsp.new_state       = onew_q;

	a_wb_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msidir_pkg::S_DONE && ram_we) |=> ovalid_q)
		else $error("write-back without response load");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && ovalid_q) |-> rsp.ready)
		else $error("pending response overwritten");

	a_mem_no_supplier: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.from_memory) |-> (rsp.supplier == '0))
		else $error("supplier set on memory fill");

	a_masks_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.downgrade_mask == '0 || rsp.invalidate_mask == '0))
		else $error("downgrade and invalidate both set");

	a_scan_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msidir_pkg::S_SCAN && sh_q[cnt_q]) |=> state_q == msidir_pkg::S_DONE)
		else $error("scan passed a set sharer bit");

endmodule
